// File: sv/column_span_blend_fill_defines.svh
// assertion helpers used by column_span_blend_fill.sv
`ifndef COLUMN_SPAN_BLEND_FILL_DEFINES_SVH
`define COLUMN_SPAN_BLEND_FILL_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CSBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/csbf_pkg.sv
package csbf_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 16;
  localparam int SR_W       = ROW_W + 2;
  localparam int DIM_W      = 9;
  localparam int ALPHA_W    = 9;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = COLOR_W / CHAN_W;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // default frame store size
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // opcodes
  localparam logic [OP_W-1:0] OP_FILL_ABOVE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL_BELOW   = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_BETWEEN = 3'd2;
  localparam logic [OP_W-1:0] OP_STAMP        = 3'd3;
  localparam logic [OP_W-1:0] OP_READ         = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ALPHA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_COLOR = 3'd4;

  // register reset values
  localparam logic [DIM_W-1:0]   RST_IMG_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]   RST_IMG_HEIGHT = 9'd256;
  localparam logic [ALPHA_W-1:0] RST_FILL_ALPHA = 9'd256;
  localparam logic [COLOR_W-1:0] RST_FILL_COLOR = 24'h000000;
  localparam logic [COLOR_W-1:0] RST_PLOT_COLOR = 24'hFFFFFF;

  // fully opaque alpha
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

endpackage

// File: sv/csbf_if.sv
// command channel
interface csbf_cmd_if import csbf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [COL_W-1:0]        column;
  logic signed [ROW_W-1:0] row_a;
  logic signed [ROW_W-1:0] row_b;

  modport source (output valid, operation, column, row_a, row_b, input ready);
  modport sink (input valid, operation, column, row_a, row_b, output ready);
endinterface

// result channel
interface csbf_rsp_if import csbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [COLOR_W-1:0] pixel_color;
  logic [CNT_W-1:0]   pixels_written;

  modport source (output valid, status, pixel_color, pixels_written, input ready);
  modport sink (input valid, status, pixel_color, pixels_written, output ready);
endinterface

// register write channel
interface csbf_cfg_if import csbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/column_span_blend_fill.sv
// Column span blend fill: a raster engine over a MAX_WIDTH x MAX_HEIGHT frame store of
// 24-bit pixels that runs one command on one pixel column at a time. Fill above, fill
// below and fill between stream the clipped span through a read-blend-write pipeline
// around the frame memory and a single blend unit, one pixel per cycle. A stamp walks its
// five points in turn, and a read fetches the addressed pixel of the column.
// Commands are taken one at a time; a finished result may wait in the output register
// while the next request is taken. After reset a clearing pass writes black to all
// MAX_WIDTH * MAX_HEIGHT pixels, one per cycle; no request is taken until it ends, while
// register writes are taken at all times.
`include "column_span_blend_fill_defines.svh"

module column_span_blend_fill import csbf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic        clk_i,
  input logic        rst_ni,
  csbf_cmd_if.sink   cmd_i,
  csbf_rsp_if.source rsp_o,
  csbf_cfg_if.sink   cfg_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PC_W  = COL_W + 2;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_STAMP = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // stamp points: centre, left, right, below, above
  localparam logic [2:0] PT_CENTRE = 3'd0;
  localparam logic [2:0] PT_LEFT   = 3'd1;
  localparam logic [2:0] PT_RIGHT  = 3'd2;
  localparam logic [2:0] PT_BELOW  = 3'd3;
  localparam logic [2:0] PT_ABOVE  = 3'd4;

  function automatic logic [AW-1:0] pix_addr(logic [RW-1:0] row, logic [COL_W:0] col);
    pix_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  // registers
  logic [2:0]              state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [DIM_W-1:0]        width_q, height_q;
  logic [ALPHA_W-1:0]      alpha_q;
  logic [COLOR_W-1:0]      fill_q, plot_q;
  logic [OP_W-1:0]         op_q, op_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic signed [ROW_W-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [RW-1:0]           row_q, row_d, hi_q, hi_d, p_row_q, p_row_d;
  logic                    p_vld_q, p_vld_d;
  logic [2:0]              pt_q, pt_d;
  logic                    status_q, status_d;
  logic [COLOR_W-1:0]      pix_q, pix_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    rsp_vld_q, rsp_vld_d;
  logic                    rsp_status_q, rsp_status_d;
  logic [COLOR_W-1:0]      rsp_pix_q, rsp_pix_d;
  logic [CNT_W-1:0]        rsp_cnt_q, rsp_cnt_d;

  // effective dimensions and alpha
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [ALPHA_W-1:0] a_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    a_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  end

  // span bounds, clipped to the image
  logic signed [SR_W-1:0] ra_s, rb_s, h_s, h_last, mn_s, mx_s;
  logic signed [SR_W-1:0] lo_raw, hi_raw, lo_c, hi_c;
  logic                   span_empty, col_ok, read_ok;

  assign ra_s   = {{(SR_W-ROW_W){ra_q[ROW_W-1]}}, ra_q};
  assign rb_s   = {{(SR_W-ROW_W){rb_q[ROW_W-1]}}, rb_q};
  assign h_s    = signed'({{(SR_W-DIM_W){1'b0}}, h_eff});
  assign h_last = h_s - SR_W'(1);
  assign mn_s   = (ra_s < rb_s) ? ra_s : rb_s;
  assign mx_s   = (ra_s < rb_s) ? rb_s : ra_s;

  always_comb begin
    case (op_q)
      OP_FILL_ABOVE: begin
        lo_raw = '0;
        hi_raw = ra_s - SR_W'(1);
      end
      OP_FILL_BELOW: begin
        lo_raw = ra_s + SR_W'(1);
        hi_raw = h_last;
      end
      default: begin
        lo_raw = mn_s + SR_W'(1);
        hi_raw = mx_s - SR_W'(1);
      end
    endcase
    lo_c = (lo_raw < 0) ? '0 : lo_raw;
    hi_c = (hi_raw > h_last) ? h_last : hi_raw;
  end

  assign span_empty = lo_c > hi_c;
  assign col_ok     = {1'b0, col_q} < w_eff;
  assign read_ok    = (ra_s >= 0) && (ra_s < h_s);

  // stamp point position and clip
  logic signed [PC_W-1:0] pc_s;
  logic signed [SR_W-1:0] pr_s;
  logic                   pt_ok;

  always_comb begin
    pc_s = signed'(PC_W'(col_q));
    pr_s = ra_s;
    case (pt_q)
      PT_CENTRE: ;
      PT_LEFT:   pc_s = signed'(PC_W'(col_q)) - PC_W'(1);
      PT_RIGHT:  pc_s = signed'(PC_W'(col_q)) + PC_W'(1);
      PT_BELOW:  pr_s = ra_s + SR_W'(1);
      PT_ABOVE:  pr_s = ra_s - SR_W'(1);
      default: ;
    endcase
    pt_ok = (pc_s >= 0) && (pc_s < signed'(PC_W'(w_eff))) && (pr_s >= 0) && (pr_s < h_s);
  end

  // memory and blend unit
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [COLOR_W-1:0] wr_data, rd_data, blend_data;

  csbf_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  csbf_blend u_blend (
    .old_i   (rd_data),
    .fill_i  (fill_q),
    .alpha_i (a_eff),
    .blend_o (blend_data)
  );

  // handshake outputs
  assign cmd_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready          = 1'b1;
  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.pixel_color    = rsp_pix_q;
  assign rsp_o.pixels_written = rsp_cnt_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    col_d        = col_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    row_d        = row_q;
    hi_d         = hi_q;
    p_row_d      = p_row_q;
    p_vld_d      = 1'b0;
    pt_d         = pt_q;
    status_d     = status_q;
    pix_d        = pix_q;
    cnt_d        = cnt_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_pix_d    = rsp_pix_q;
    rsp_cnt_d    = rsp_cnt_q;
    wr_en        = 1'b0;
    wr_addr      = pix_addr(p_row_q, {1'b0, col_q});
    wr_data      = blend_data;
    rd_en        = 1'b0;
    rd_addr      = pix_addr(row_q, {1'b0, col_q});

    // write back of the pixel read in the previous cycle
    if (p_vld_q) begin
      wr_en = 1'b1;
      cnt_d = cnt_q + CNT_W'(1);
    end

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d    = cmd_i.operation;
          col_d   = cmd_i.column;
          ra_d    = cmd_i.row_a;
          rb_d    = cmd_i.row_b;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        status_d = 1'b0;
        pix_d    = '0;
        cnt_d    = '0;
        state_d  = S_DONE;
        if (op_q <= OP_READ) begin
          if (!col_ok) begin
            status_d = 1'b1;
          end else if (op_q inside {OP_FILL_ABOVE, OP_FILL_BELOW, OP_FILL_BETWEEN}) begin
            if (!span_empty) begin
              row_d   = lo_c[RW-1:0];
              hi_d    = hi_c[RW-1:0];
              state_d = S_FILL;
            end
          end else if (op_q == OP_STAMP) begin
            pt_d    = PT_CENTRE;
            state_d = S_STAMP;
          end else if (read_ok) begin
            rd_en   = 1'b1;
            rd_addr = pix_addr(ra_s[RW-1:0], {1'b0, col_q});
            state_d = S_READ;
          end
        end
      end
      S_FILL: begin
        rd_en   = 1'b1;
        p_vld_d = 1'b1;
        p_row_d = row_q;
        if (row_q == hi_q) begin
          state_d = S_DRAIN;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_STAMP: begin
        if (pt_ok) begin
          wr_en   = 1'b1;
          wr_addr = pix_addr(pr_s[RW-1:0], pc_s[COL_W:0]);
          wr_data = plot_q;
          cnt_d   = cnt_q + CNT_W'(1);
        end
        if (pt_q == PT_ABOVE) begin
          state_d = S_DONE;
        end else begin
          pt_d = pt_q + 3'd1;
        end
      end
      S_READ: begin
        pix_d   = rd_data;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d    = 1'b1;
          rsp_status_d = status_q;
          rsp_pix_d    = pix_q;
          rsp_cnt_d    = cnt_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      p_vld_q   <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      p_vld_q   <= p_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMG_WIDTH;
      height_q <= RST_IMG_HEIGHT;
      alpha_q  <= RST_FILL_ALPHA;
      fill_q   <= RST_FILL_COLOR;
      plot_q   <= RST_PLOT_COLOR;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IMG_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_IMG_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_FILL_ALPHA: alpha_q  <= cfg_i.data[ALPHA_W-1:0];
        REG_FILL_COLOR: fill_q   <= cfg_i.data[COLOR_W-1:0];
        REG_PLOT_COLOR: plot_q   <= cfg_i.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    col_q        <= col_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    row_q        <= row_d;
    hi_q         <= hi_d;
    p_row_q      <= p_row_d;
    pt_q         <= pt_d;
    status_q     <= status_d;
    pix_q        <= pix_d;
    cnt_q        <= cnt_d;
    rsp_status_q <= rsp_status_d;
    rsp_pix_q    <= rsp_pix_d;
    rsp_cnt_q    <= rsp_cnt_d;
  end

  // checks
  `CSBF_ASSERT_NEXT(a_accept_setup, (cmd_i.valid && cmd_i.ready), (state_q == S_SETUP),
    "accepted request did not start decode")
  `CSBF_ASSERT_SAME(a_fill_bound, (state_q == S_FILL), (row_q <= hi_q),
    "fill read row ran past span end")
  `CSBF_ASSERT_SAME(a_wb_state, p_vld_q, (state_q == S_FILL || state_q == S_DRAIN),
    "blend write back outside a span fill")
  `CSBF_ASSERT_SAME(a_stamp_count, (state_q == S_STAMP), (cnt_q <= CNT_W'(pt_q)),
    "stamp count exceeds points visited")

endmodule

// File: sv/csbf_frame_mem.sv
module csbf_frame_mem import csbf_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [COLOR_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [COLOR_W-1:0] rd_data_o
);

  logic [COLOR_W-1:0] mem_q [DEPTH];
  logic [COLOR_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/csbf_blend.sv
module csbf_blend import csbf_pkg::*; (
  input  logic [COLOR_W-1:0] old_i,
  input  logic [COLOR_W-1:0] fill_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic [COLOR_W-1:0] blend_o
);

  logic [ALPHA_W-1:0] inv_alpha;

  // weight of the old pixel
  assign inv_alpha = ALPHA_ONE - alpha_i;

  // per channel ((256 - a) * old + a * fill) >> 8
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic [CHAN_W-1:0]         old_ch;
    logic [CHAN_W-1:0]         fill_ch;
    logic [ALPHA_W+CHAN_W-1:0] prod_old;
    logic [ALPHA_W+CHAN_W-1:0] prod_fill;
    logic [ALPHA_W+CHAN_W:0]   sum;

    assign old_ch    = old_i[c*CHAN_W +: CHAN_W];
    assign fill_ch   = fill_i[c*CHAN_W +: CHAN_W];
    assign prod_old  = inv_alpha * old_ch;
    assign prod_fill = alpha_i * fill_ch;
    assign sum       = {1'b0, prod_old} + {1'b0, prod_fill};
    assign blend_o[c*CHAN_W +: CHAN_W] = sum[2*CHAN_W-1:CHAN_W];
  end

endmodule
